[rtl/annulus_block_mask_finder_unit_defines.svh]
// Assertion macros for the annulus block mask finder.
`ifndef ANNULUS_BLOCK_MASK_FINDER_UNIT_DEFINES_SVH
`define ANNULUS_BLOCK_MASK_FINDER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ABM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property during reset as well.
`define ABM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/abmf_pkg.sv]
package abmf_pkg;

  localparam int unsigned MaxBlocksDefault = 64;
  localparam int unsigned FracBitsDefault  = 16;
  localparam int unsigned Corners          = 4;
  localparam int unsigned CoordW           = 32;
  localparam int unsigned RadW             = 31;
  localparam int unsigned SizeW            = 7;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 31;
  localparam int unsigned SlotW            = 8;
  localparam int unsigned StoreDepth       = 256;
  localparam int unsigned RcW              = 6;
  localparam int unsigned DistW            = 65;
  localparam int unsigned DivW             = 34;

  localparam logic [CfgIdxW-1:0] CfgInner = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOuter = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSide  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRows  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCols  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTotal = 3'd5;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SETUP,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_BLK_START,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_SQ_Y,
    ST_SQ_X,
    ST_ACC,
    ST_DECIDE,
    ST_OUT
  } state_e;

endpackage

[rtl/abmf_ram.sv]
module abmf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/annulus_block_mask_finder_unit.sv]
// Annulus block mask finder. A load transaction (opcode 0) writes one corner into
// two 256 x 32 corner RAMs. A query transaction (opcode 1) runs three restoring
// divisions (each: setup, 34 quotient bits one per cycle, and a bound update) for
// the window bounds, then walks the window one block at a time: each of the four
// corners takes a RAM read, a wait, a y and an x step on the single shared squarer
// and an accumulate step, plus a start and a decision step per block. The query
// accepts no new transaction until its mask has been taken.
module annulus_block_mask_finder_unit
  import abmf_pkg::*;
#(
  parameter int unsigned MaxBlocks = MaxBlocksDefault,
  parameter int unsigned FracBits  = FracBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic [SlotW-1:0]         corner_slot_i,
  input  logic signed [CoordW-1:0] corner_y_i,
  input  logic signed [CoordW-1:0] corner_x_i,
  input  logic [RcW-1:0]           point_row_i,
  input  logic [RcW-1:0]           point_col_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_x_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [MaxBlocks-1:0]     target_mask_o
);

  `include "annulus_block_mask_finder_unit_defines.svh"

  localparam int unsigned BlkW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam logic signed [DivW:0] BoundZero = '0;

  // Fractional position does not change any compare, so FracBits only documents.
  localparam int unsigned FracUnused = FracBits;

  // configuration
  logic [RadW-1:0]  inner_q, outer_q, side_q;
  logic [SizeW-1:0] rows_q, cols_q, total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= '0;
      outer_q <= '0;
      side_q  <= RadW'(65536);
      rows_q  <= SizeW'(8);
      cols_q  <= SizeW'(8);
      total_q <= SizeW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInner: inner_q <= cfg_data_i[RadW-1:0];
        CfgOuter: outer_q <= cfg_data_i[RadW-1:0];
        CfgSide:  side_q  <= cfg_data_i[RadW-1:0];
        CfgRows:  rows_q  <= cfg_data_i[SizeW-1:0];
        CfgCols:  cols_q  <= cfg_data_i[SizeW-1:0];
        CfgTotal: total_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // corner RAMs
  logic             in_acc;
  logic             ram_we;
  logic [SlotW-1:0] ram_raddr;
  logic [CoordW-1:0] ry_rd, rx_rd;

  assign in_acc = in_valid_i && !in_stall_o;
  assign ram_we = in_acc && (opcode_i == OpLoad);

  abmf_ram #(.Width(CoordW), .Depth(StoreDepth)) u_ram_y (
    .clk_i, .we_i(ram_we), .waddr_i(corner_slot_i), .wdata_i(corner_y_i),
    .raddr_i(ram_raddr), .rdata_o(ry_rd)
  );
  abmf_ram #(.Width(CoordW), .Depth(StoreDepth)) u_ram_x (
    .clk_i, .we_i(ram_we), .waddr_i(corner_slot_i), .wdata_i(corner_x_i),
    .raddr_i(ram_raddr), .rdata_o(rx_rd)
  );

  // sequencer state
  state_e state_q, state_d;
  logic [RcW-1:0] prow_q, pcol_q;
  logic signed [CoordW-1:0] py_q, px_q;
  logic [1:0] div_sel_q;                  // 0: col start, 1: col end, 2: row end
  logic [DivCntW-1:0] div_cnt_q;
  logic [DivW-1:0] div_num_q, div_quo_q;
  logic [DivW:0] div_rem_q;
  logic div_neg_q;
  logic signed [DivW:0] cs_q, ce_q;       // signed bounds
  logic [SizeW:0] row_q, col_q;
  logic [SizeW:0] cs_lim_q, ce_lim_q, re_lim_q;
  logic [1:0] corner_q;
  logic [CoordW:0] dx_q;
  logic [DistW-1:0] acc_q, dmin_q, dmax_q;
  logic [2*CoordW-1:0] sq_q;
  logic [MaxBlocks-1:0] mask_q;
  logic [2*RadW-1:0] in_sq_q, out_sq_q;

  // shared squarer on 33-bit magnitudes (bit 32 stays clear, magnitudes are below 2^32)
  logic [CoordW:0] sq_in;
  logic [2*CoordW+1:0] sq_full;
  assign sq_full = (2*CoordW+2)'(sq_in) * (2*CoordW+2)'(sq_in);

  logic signed [CoordW:0] ry_s, rx_s, py_s, px_s;
  logic signed [CoordW+1:0] ddy, ddx;
  logic [CoordW:0] ady, adx;
  assign ry_s = {ry_rd[CoordW-1], ry_rd};
  assign rx_s = {rx_rd[CoordW-1], rx_rd};
  assign py_s = {py_q[CoordW-1], py_q};
  assign px_s = {px_q[CoordW-1], px_q};
  assign ddy  = {ry_s[CoordW], ry_s} - {py_s[CoordW], py_s};
  assign ddx  = {rx_s[CoordW], rx_s} - {px_s[CoordW], px_s};
  assign ady  = ddy[CoordW+1] ? (CoordW+1)'(0) - ddy[CoordW:0] : ddy[CoordW:0];
  assign adx  = ddx[CoordW+1] ? (CoordW+1)'(0) - ddx[CoordW:0] : ddx[CoordW:0];

  // divider numerator for each bound
  logic signed [DivW-1:0] num_s;
  logic [RadW-1:0] side_eff;
  assign side_eff = (side_q == '0) ? RadW'(1) : side_q;
  always_comb begin
    case (div_sel_q)
      2'd0:    num_s = DivW'($signed({1'b0, outer_q})) - DivW'(px_s);
      2'd1:    num_s = DivW'($signed({1'b0, outer_q})) + DivW'(px_s);
      default: num_s = DivW'($signed({1'b0, outer_q})) + DivW'(py_s);
    endcase
  end

  logic [DivW:0] rem_sh, rem_sub;
  assign rem_sh  = {div_rem_q[DivW-1:0], div_num_q[DivW-1]};
  assign rem_sub = rem_sh - (DivW+1)'(side_eff);

  logic signed [DivW:0] quo_s;
  assign quo_s = div_neg_q ? -$signed({1'b0, div_quo_q}) : $signed({1'b0, div_quo_q});

  // block index and tests
  logic [2*SizeW+1:0] blk_idx;
  logic [SizeW:0] total_eff;
  logic blk_ok;
  logic [DistW-1:0] sum_d;
  assign total_eff = (total_q > SizeW'(MaxBlocks)) ? (SizeW+1)'(MaxBlocks)
                                                   : {1'b0, total_q};
  assign blk_idx = (2*SizeW+2)'(row_q) * (2*SizeW+2)'(cols_q) + (2*SizeW+2)'(col_q);
  assign blk_ok  = blk_idx < (2*SizeW+2)'(total_eff);
  assign sum_d   = acc_q + DistW'(sq_q);
  assign ram_raddr = SlotW'({blk_idx[BlkW-1:0], corner_q});

  logic skip_in, skip_out, mark;
  assign skip_in  = dmax_q < DistW'(in_sq_q);
  assign skip_out = (dmin_q > DistW'(out_sq_q)) && (row_q != (SizeW+1)'(prow_q))
                    && (col_q != (SizeW+1)'(pcol_q));
  assign mark     = !skip_in && !skip_out &&
                    ((row_q > (SizeW+1)'(prow_q)) || (col_q >= (SizeW+1)'(pcol_q)));

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign target_mask_o = mask_q;

  always_comb begin
    state_d = state_q;
    sq_in   = ady;
    case (state_q)
      ST_IDLE:      if (in_acc && opcode_i == OpQuery) state_d = ST_DIV_SETUP;
      ST_DIV_SETUP: state_d = ST_DIV_RUN;
      ST_DIV_RUN:   if (div_cnt_q == DivCntW'(1)) state_d = ST_DIV_DONE;
      ST_DIV_DONE:  state_d = (div_sel_q == 2'd2) ? ST_BLK_START : ST_DIV_SETUP;
      ST_BLK_START: begin
        if (row_q >= re_lim_q || cs_lim_q >= ce_lim_q) state_d = ST_OUT;
        else if (!blk_ok) state_d = ST_OUT;
        else state_d = ST_RD_ISSUE;
      end
      ST_RD_ISSUE:  state_d = ST_RD_WAIT;
      ST_RD_WAIT:   state_d = ST_SQ_Y;
      ST_SQ_Y: begin
        sq_in   = ady;
        state_d = ST_SQ_X;
      end
      ST_SQ_X: begin
        sq_in   = adx;
        state_d = ST_ACC;
      end
      ST_ACC:       state_d = (corner_q == 2'd3) ? ST_DECIDE : ST_RD_ISSUE;
      ST_DECIDE:    state_d = ST_BLK_START;
      ST_OUT:       if (!out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance to the next block, skipping to the next row at the column end.
  logic [SizeW:0] col_nx, row_nx;
  always_comb begin
    col_nx = col_q + (SizeW+1)'(1);
    row_nx = row_q;
    if (col_nx >= ce_lim_q) begin
      col_nx = cs_lim_q;
      row_nx = row_q + (SizeW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && opcode_i == OpQuery) begin
          prow_q    <= point_row_i;
          pcol_q    <= point_col_i;
          py_q      <= point_y_i;
          px_q      <= point_x_i;
          div_sel_q <= 2'd0;
          mask_q    <= '0;
          in_sq_q   <= (2*RadW)'(inner_q) * (2*RadW)'(inner_q);
          out_sq_q  <= (2*RadW)'(outer_q) * (2*RadW)'(outer_q);
        end
      end
      ST_DIV_SETUP: begin
        div_neg_q <= num_s[DivW-1];
        div_num_q <= num_s[DivW-1] ? DivW'(0) - num_s : num_s;
        div_rem_q <= '0;
        div_quo_q <= '0;
        div_cnt_q <= DivCntW'(DivW);
      end
      ST_DIV_RUN: begin
        div_num_q <= {div_num_q[DivW-2:0], 1'b0};
        div_cnt_q <= div_cnt_q - DivCntW'(1);
        if (!rem_sub[DivW]) begin
          div_rem_q <= rem_sub;
          div_quo_q <= {div_quo_q[DivW-2:0], 1'b1};
        end else begin
          div_rem_q <= rem_sh;
          div_quo_q <= {div_quo_q[DivW-2:0], 1'b0};
        end
      end
      ST_DIV_DONE: begin
        case (div_sel_q)
          2'd0: cs_q <= -quo_s - (DivW+1)'(1);
          2'd1: ce_q <= quo_s + (DivW+1)'(2);
          default: ;
        endcase
        div_sel_q <= div_sel_q + 2'd1;
        if (div_sel_q == 2'd2) begin
          logic signed [DivW:0] cs_c, ce_c, re_c;
          cs_c = (cs_q < BoundZero) ? BoundZero : cs_q;
          ce_c = (ce_q > $signed((DivW+1)'(cols_q))) ? $signed((DivW+1)'(cols_q)) : ce_q;
          re_c = quo_s + (DivW+1)'(1);
          re_c = (re_c > $signed((DivW+1)'(rows_q))) ? $signed((DivW+1)'(rows_q)) : re_c;
          if (re_c < BoundZero) re_c = BoundZero;
          if (ce_c < BoundZero) ce_c = BoundZero;
          if (cs_c > $signed((DivW+1)'(MaxBlocks))) cs_c = (DivW+1)'(MaxBlocks);
          cs_lim_q <= (SizeW+1)'(cs_c);
          ce_lim_q <= (SizeW+1)'(ce_c);
          re_lim_q <= (SizeW+1)'(re_c);
          col_q    <= (SizeW+1)'(cs_c);
          row_q    <= (SizeW+1)'(prow_q);
        end
      end
      ST_BLK_START: begin
        corner_q <= 2'd0;
        acc_q    <= '0;
      end
      ST_SQ_Y: begin
        sq_q <= sq_full[2*CoordW-1:0];
        dx_q <= adx;
      end
      ST_SQ_X: begin
        acc_q <= DistW'(sq_q);
        sq_q  <= sq_full[2*CoordW-1:0];
      end
      ST_ACC: begin
        if (corner_q == 2'd0 || sum_d < dmin_q) dmin_q <= sum_d;
        if (corner_q == 2'd0 || sum_d > dmax_q) dmax_q <= sum_d;
        corner_q <= corner_q + 2'd1;
      end
      ST_DECIDE: begin
        if (mark) mask_q[blk_idx[BlkW-1:0]] <= 1'b1;
        col_q <= col_nx;
        row_q <= row_nx;
      end
      default: ;
    endcase
  end

  logic unused_ok;
  assign unused_ok = ^{dx_q, sq_full[2*CoordW+1:2*CoordW], FracUnused[0]};

  `ABM_ASSERT(a_busy_stalls, clk_i, rst_ni,
    (state_q != ST_IDLE) |-> in_stall_o, "input not stalled while busy")
  `ABM_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(target_mask_o)),
    "result changed while stalled")
  `ABM_ASSERT(a_query_starts, clk_i, rst_ni,
    (in_acc && opcode_i == OpQuery) |=> (state_q == ST_DIV_SETUP),
    "query did not start division")
  `ABM_ASSERT(a_load_stays_idle, clk_i, rst_ni,
    (in_acc && opcode_i == OpLoad) |=> (state_q == ST_IDLE), "load left idle")

endmodule
